FILE: sv/lbe_pkg.sv
// Shared types, constants and helpers for the Lagrange basis evaluator.
`timescale 1ns / 1ps
`default_nettype none
package lbe_pkg;

	localparam int DEF_MAX_NODES = 16;
	localparam int DEF_FRAC_BITS = 28;
	localparam int DATA_W        = 32;
	localparam int DIV_STEPS     = 32;

	// request kinds on s_tuser
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_K,
		ST_LD_K,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_LOOP_RD,
		ST_LOOP_SUB,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_MUL,
		ST_MCLIP,
		ST_DONE
	} lbe_state_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic              done;
		logic              big;   // quotient >= 2^32
		logic [DATA_W-1:0] quo;
	} div_res_t;

	typedef struct packed {
		logic [DATA_W-1:0] val;
		logic              sat;
	} clip_t;

	// sign and magnitude to saturated 32-bit two's complement
	function automatic clip_t clip32(input logic neg, input logic [63:0] mag);
		clip_t r;
		r.sat = 1'b0;
		if (neg) begin
			if (mag > 64'h0000_0000_8000_0000) begin
				r.sat = 1'b1;
				r.val = 32'h8000_0000;
			end else begin
				r.val = 32'(-mag[31:0]);
			end
		end else begin
			if (mag > 64'h0000_0000_7FFF_FFFF) begin
				r.sat = 1'b1;
				r.val = 32'h7FFF_FFFF;
			end else begin
				r.val = mag[31:0];
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: sv/lagrange_basis_evaluator_core.sv
// Top level: node table, sequencer and datapath of the Lagrange basis evaluator.
//
//  port group | dir | payload                                        | transfer
//  -----------+-----+------------------------------------------------+-----------------
//  s_*        | in  | tuser: operation; tdata: node_index, node_value,| tvalid & tready
//             |     |   point, basis_index                           |
//  m_*        | out | tdata: basis_value; tuser: saturated,           | tvalid & tready
//             |     |   zero_divisor                                 |
//  cfg_*      | in  | node_count (5 bits)                            | cfg_we
//
// A node write is accepted while idle; s_tready stays high there for back-to-back writes.
// An evaluate request of n nodes first runs a duplicate scan, one read and one compare
// per node through the registered table read port, then per other node one read, one
// subtract, one divider start, a wait on the single bit-serial divider, one multiply
// and one clip. A quotient of 2^32 or more is flagged done in the cycle after the
// divider start, without running the bit-serial steps.
// Results sit in an output register; a stalled m_tready only holds the sequencer
// once the next result is ready. Reset clears control and node_count (to 1); the
// node table is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module lagrange_basis_evaluator_core
	import lbe_pkg::*;
#(
	parameter int MAX_NODES = DEF_MAX_NODES,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [71:0] s_tdata,   // [3:0] node_index, [35:4] node_value,
	                                    // [67:36] point, [71:68] basis_index
	input  wire logic        s_tuser,   // [0] operation
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [31:0] m_tdata,   // [31:0] basis_value
	output      logic [1:0]  m_tuser,   // [0] saturated, [1] zero_divisor
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata
);

	localparam int NIDX = $clog2(MAX_NODES);
	localparam int CW   = $clog2(MAX_NODES + 1);
	localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

	lbe_state_t state_q, state_d;

	// request fields
	logic        req_op;
	logic [3:0]  req_nidx;
	logic [31:0] req_nval;
	logic [31:0] req_point;
	logic [3:0]  req_k;
	logic        accept;

	assign req_op    = s_tuser;
	assign req_nidx  = s_tdata[3:0];
	assign req_nval  = s_tdata[35:4];
	assign req_point = s_tdata[67:36];
	assign req_k     = s_tdata[71:68];
	assign accept    = s_tvalid && s_tready;

	logic [4:0] node_count_q;

	// node count clamped to 1..MAX_NODES
	logic [7:0] cnt_ext, n8, k_ext, ni_ext;
	assign cnt_ext = 8'(node_count_q);
	assign k_ext   = 8'(req_k);
	assign ni_ext  = 8'(req_nidx);
	always_comb begin
		if (cnt_ext == 8'd0)
			n8 = 8'd1;
		else if (cnt_ext > 8'(MAX_NODES))
			n8 = 8'(MAX_NODES);
		else
			n8 = cnt_ext;
	end

	// node table
	logic [31:0]     mem [MAX_NODES];
	logic [31:0]     rd_q;
	logic [NIDX-1:0] raddr;
	logic            mem_we;

	// sequencer registers
	logic [CW-1:0] n_q, k_q, j_q;
	logic [31:0]   x_q, xk_q, prod_q, q_q;
	logic          sat_q, zd_q;
	logic          num_neg_q, den_neg_q, mul_neg_q;
	logic [32:0]   num_mag_q, den_mag_q;
	logic [63:0]   mprod_q;

	// output register
	logic        m_valid_q;
	logic [31:0] m_data_q;
	logic [1:0]  m_user_q;

	// control from the output decode
	logic rd_k_sel;
	logic div_start;
	logic out_load;

	div_res_t div_res;

	logic j_last, j_is_k;
	assign j_last = j_q == CW'(n_q - CW'(1));
	assign j_is_k = j_q == k_q;

	assign mem_we = accept && req_op == OP_WRITE && ni_ext < 8'(MAX_NODES);
	assign raddr  = rd_k_sel ? k_q[NIDX-1:0] : j_q[NIDX-1:0];

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[ni_ext[NIDX-1:0]] <= req_nval;
		rd_q <= mem[raddr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && req_op == OP_EVAL)
					state_d = (k_ext < n8) ? ST_RD_K : ST_DONE;
			end
			ST_RD_K:     state_d = ST_LD_K;
			ST_LD_K:     state_d = ST_SCAN_RD;
			ST_SCAN_RD:  state_d = ST_SCAN_CMP;
			ST_SCAN_CMP: begin
				if (!j_is_k && rd_q == xk_q)
					state_d = ST_DONE;
				else if (j_last)
					state_d = ST_LOOP_RD;
				else
					state_d = ST_SCAN_RD;
			end
			ST_LOOP_RD: begin
				if (!j_is_k)
					state_d = ST_LOOP_SUB;
				else if (j_last)
					state_d = ST_DONE;
			end
			ST_LOOP_SUB: state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_res.done)
					state_d = ST_MUL;
			end
			ST_MUL:      state_d = ST_MCLIP;
			ST_MCLIP:    state_d = j_last ? ST_DONE : ST_LOOP_RD;
			ST_DONE: begin
				if (!m_valid_q || m_tready)
					state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// output decode
	always_comb begin
		s_tready  = 1'b0;
		rd_k_sel  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE:   s_tready  = 1'b1;
			ST_RD_K:   rd_k_sel  = 1'b1;
			ST_DIV_GO: div_start = 1'b1;
			ST_DONE:   out_load  = !m_valid_q || m_tready;
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= 5'd1;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				node_count_q <= cfg_wdata;
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	// datapath
	logic signed [32:0] num_s, den_s;
	clip_t              q_clip, p_clip;
	logic [63:0]        q_mag;
	logic               q_neg;
	logic [31:0]        prod_abs, q_abs;
	logic [63:0]        pm;

	assign num_s = {x_q[31], x_q} - {rd_q[31], rd_q};
	assign den_s = {xk_q[31], xk_q} - {rd_q[31], rd_q};

	assign q_mag  = div_res.big ? 64'h0000_0001_0000_0000 : {32'b0, div_res.quo};
	assign q_neg  = (num_neg_q ^ den_neg_q) && (q_mag != 64'd0);
	assign q_clip = clip32(q_neg, q_mag);

	assign prod_abs = prod_q[31] ? 32'(-prod_q) : prod_q;
	assign q_abs    = q_q[31] ? 32'(-q_q) : q_q;

	assign pm     = mprod_q >> FRAC_BITS;
	assign p_clip = clip32(mul_neg_q && pm != 64'd0, pm);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q    <= req_point;
				k_q    <= k_ext[CW-1:0];
				n_q    <= n8[CW-1:0];
				prod_q <= '0;
				sat_q  <= 1'b0;
				zd_q   <= 1'b0;
			end
			ST_LD_K: begin
				xk_q   <= rd_q;
				j_q    <= '0;
				prod_q <= ONE;
			end
			ST_SCAN_CMP: begin
				if (!j_is_k && rd_q == xk_q) begin
					zd_q   <= 1'b1;
					prod_q <= '0;
				end else if (j_last) begin
					j_q <= '0;
				end else begin
					j_q <= j_q + CW'(1);
				end
			end
			ST_LOOP_RD: begin
				if (j_is_k && !j_last)
					j_q <= j_q + CW'(1);
			end
			ST_LOOP_SUB: begin
				num_neg_q <= num_s[32];
				den_neg_q <= den_s[32];
				num_mag_q <= num_s[32] ? 33'(-num_s) : 33'(num_s);
				den_mag_q <= den_s[32] ? 33'(-den_s) : 33'(den_s);
			end
			ST_DIV_WAIT: begin
				if (div_res.done) begin
					q_q   <= q_clip.val;
					sat_q <= sat_q | q_clip.sat;
				end
			end
			ST_MUL: begin
				mprod_q   <= 64'(prod_abs) * 64'(q_abs);
				mul_neg_q <= prod_q[31] ^ q_q[31];
			end
			ST_MCLIP: begin
				prod_q <= p_clip.val;
				sat_q  <= sat_q | p_clip.sat;
				if (!j_last)
					j_q <= j_q + CW'(1);
			end
			default: begin
				j_q <= j_q;
			end
		endcase
		if (out_load) begin
			m_data_q <= prod_q;
			m_user_q <= {zd_q, sat_q};
		end
	end

	lbe_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_mag(num_mag_q),
		.den_mag(den_mag_q),
		.res    (div_res)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	a_zd_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == 32'd0 && !m_tuser[0])
		else $error("duplicate-node result not clean zero");
	a_j_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_CMP || state_q == ST_LOOP_RD || state_q == ST_MCLIP)
		|-> j_q < n_q) else $error("node counter past node count");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !div_res.done) else $error("divider done while idle");

endmodule
`default_nettype wire

FILE: sv/lbe_div.sv
// Radix-2 restoring divider: (num_mag * 2^FRAC_BITS) / den_mag, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lbe_div
	import lbe_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [32:0] num_mag,
	input  wire logic [32:0] den_mag,
	output      div_res_t    res
);

	logic [64:0] ext;
	logic [32:0] rem_q;
	logic [32:0] den_q;
	logic [31:0] low_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic        big_q;
	logic [33:0] trial;
	logic [33:0] diff;
	logic        ge;

	// dividend split: upper part seeds the remainder, lower 32 bits are brought down
	assign ext   = {32'b0, num_mag} << FRAC_BITS;
	assign trial = {rem_q, low_q[31]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			if (ext[64:32] >= den_mag) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= 6'(DIV_STEPS);
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den_mag;
			big_q <= ext[64:32] >= den_mag;
			rem_q <= ext[64:32];
			low_q <= ext[31:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[32:0] : trial[32:0];
			low_q <= {low_q[30:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.big  = big_q;
	assign res.quo  = low_q;

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < den_q) else $error("divider remainder not below divisor");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");

endmodule
`default_nettype wire
